// ===== rtl/core/vacs_pkg.sv =====
// Shared types, constants and saturation helpers for the Viterbi ACS stage.
// No dependencies; every module of the block imports this package.
package vacs_pkg;

	localparam int MaxStateLog2 = 8;
	localparam int MinStateLog2 = 2;
	localparam int MetricW      = 16;
	localparam int SumW         = 24;
	localparam int CntW         = 6;
	localparam int LogW         = 4;
	localparam int SpreadW      = 15;
	localparam int CfgIdxW      = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgScaleOffset = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgScaleBypass = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgSelectMin   = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgTrellisLog2 = 2'd3;

	localparam logic [LogW-1:0] TrellisLog2Rst = 4'd6;

	localparam logic signed [MetricW-1:0] MetricMax  = 16'sh7FFF;
	localparam logic signed [MetricW-1:0] MetricMin  = 16'sh8000;
	localparam logic signed [MetricW-1:0] ExtInitMax = -16'sd32767;
	localparam logic [SpreadW-1:0]        SpreadMax  = 15'h7FFF;

	typedef logic signed [MetricW-1:0] metric_t;

	typedef struct packed {
		metric_t          scale_offset;
		logic             scale_bypass;
		logic             select_min;
		logic [LogW-1:0]  trellis_log2;
	} cfg_t;

	typedef struct packed {
		metric_t    surv_first;
		metric_t    surv_second;
		metric_t    cand_t1;
		metric_t    cand_t2;
		metric_t    cand_t3;
		metric_t    cand_t4;
		logic [1:0] dec;
	} bfly_t;

	typedef struct packed {
		logic [CntW-1:0]    pair_index;
		logic               stage_last;
		logic [SpreadW-1:0] spread;
		metric_t            mean;
	} acc_out_t;

	// clamp an 18-bit signed value to the 16-bit metric range
	function automatic metric_t sat16(input logic signed [MetricW+1:0] v);
		if (v < 18'(MetricMin))
			return MetricMin;
		else if (v > 18'(MetricMax))
			return MetricMax;
		else
			return v[MetricW-1:0];
	endfunction

	// keep the larger value, or the smaller one in min mode
	function automatic metric_t pick(input logic use_min, input metric_t x, input metric_t y);
		if (use_min)
			return (x < y) ? x : y;
		else
			return (x > y) ? x : y;
	endfunction

endpackage

// ===== rtl/core/vacs_bfly.sv =====
// One radix-2 butterfly: offset removal, saturated add/subtract, survivor select.
// Pure combinational; depends on vacs_pkg.
module vacs_bfly import vacs_pkg::*; (
	input  metric_t p1,
	input  metric_t p2,
	input  metric_t m1,
	input  metric_t m2,
	input  metric_t offset,
	input  logic    use_min,
	output bfly_t   res
);

	metric_t a, b, t1, t2, t3, t4;
	logic    ge_first, ge_second, d0, d1;

	always_comb begin
		a  = sat16(18'(p1) - 18'(offset));
		b  = sat16(18'(p2) - 18'(offset));
		t1 = sat16(18'(a) + 18'(m1));
		t2 = sat16(18'(b) + 18'(m2));
		t3 = sat16(18'(a) - 18'(m1));
		t4 = sat16(18'(b) - 18'(m2));
		ge_first  = (t1 >= t2);
		ge_second = (t3 >= t4);
		// max mode: first state wins ties; min mode: second state wins ties
		d0 = use_min ? ge_first : !ge_first;
		d1 = use_min ? ge_second : !ge_second;
		res.surv_first  = d0 ? t2 : t1;
		res.surv_second = d1 ? t4 : t3;
		res.cand_t1     = t1;
		res.cand_t2     = t2;
		res.cand_t3     = t3;
		res.cand_t4     = t4;
		res.dec         = {d1, d0};
	end

endmodule

// ===== rtl/core/vacs_acc.sv =====
// Stage bookkeeping: pair counter, running extremes and metric sum, spread and mean.
// Depends on vacs_pkg; fed by two vacs_bfly results.
module vacs_acc import vacs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  cfg_t     cfg,
	input  bfly_t    bf_a,
	input  bfly_t    bf_b,
	output acc_out_t res
);

	logic [CntW-1:0]         cnt_q;
	metric_t                 ext_even_q, ext_odd_q;
	logic signed [SumW-1:0]  sum_q;

	logic [LogW-1:0]         k_eff;
	logic [CntW-1:0]         last_index;
	logic                    start, last;
	metric_t                 ext_init, e0, o0, e_new, o_new;
	logic signed [MetricW+1:0] sum4;
	logic signed [SumW-1:0]  s0, sum_new, shifted;
	logic signed [MetricW:0] diff;
	logic [MetricW:0]        mag;

	always_comb begin
		if (cfg.trellis_log2 < LogW'(MinStateLog2))
			k_eff = LogW'(MinStateLog2);
		else if (cfg.trellis_log2 > LogW'(MaxStateLog2))
			k_eff = LogW'(MaxStateLog2);
		else
			k_eff = cfg.trellis_log2;
		last_index = CntW'((7'd1 << (k_eff - LogW'(MinStateLog2))) - 7'd1);

		start    = (cnt_q == '0);
		last     = (cnt_q >= last_index);
		ext_init = cfg.select_min ? MetricMax : ExtInitMax;
		e0       = start ? ext_init : ext_even_q;
		o0       = start ? ext_init : ext_odd_q;
		e_new    = pick(cfg.select_min,
			pick(cfg.select_min, pick(cfg.select_min, e0, bf_a.cand_t1), bf_a.cand_t3),
			pick(cfg.select_min, bf_b.cand_t1, bf_b.cand_t3));
		o_new    = pick(cfg.select_min,
			pick(cfg.select_min, pick(cfg.select_min, o0, bf_a.cand_t2), bf_a.cand_t4),
			pick(cfg.select_min, bf_b.cand_t2, bf_b.cand_t4));

		sum4    = 18'(bf_a.surv_first) + 18'(bf_a.surv_second)
			+ 18'(bf_b.surv_first) + 18'(bf_b.surv_second);
		s0      = start ? '0 : sum_q;
		sum_new = s0 + SumW'(sum4);
		shifted = sum_new >>> k_eff;

		diff = 17'(o_new) - 17'(e_new);
		mag  = diff[MetricW] ? 17'(-diff) : 17'(diff);

		res.pair_index = cnt_q;
		res.stage_last = last;
		res.spread     = '0;
		res.mean       = '0;
		if (last) begin
			res.spread = (mag > 17'(SpreadMax)) ? SpreadMax : mag[SpreadW-1:0];
			res.mean   = shifted[MetricW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			ext_even_q <= ExtInitMax;
			ext_odd_q  <= ExtInitMax;
			sum_q      <= '0;
		end else if (step) begin
			cnt_q      <= last ? '0 : cnt_q + CntW'(1);
			ext_even_q <= e_new;
			ext_odd_q  <= o_new;
			sum_q      <= sum_new;
		end
	end

endmodule

// ===== rtl/core/viterbi_acs_stage_core.sv =====
// Viterbi radix-2 ACS stage: one butterfly pair per item, 2^(k-2) items per stage.
// Registers: the input register, then the result register; an item waits in the first while the second is held.
// Throughput: one item per cycle while m_tready stays high; the running extremes and sum update with each item.
// Reset (arst_n low, asynchronous): pipeline empties, pair counter and sum clear,
// registers return to offset 0, no bypass, max mode, trellis_log2 = 6.
// Depends on vacs_pkg, vacs_bfly, vacs_acc.
module viterbi_acs_stage_core import vacs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,

	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	// [15:0] path_a_low, [31:16] path_a_high, [47:32] branch_a_low,
	// [63:48] branch_a_high, [79:64] path_b_low, [95:80] path_b_high,
	// [111:96] branch_b_low, [127:112] branch_b_high
	input  logic [127:0]        s_tdata,

	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	// [15:0] even_word_low, [31:16] even_word_high, [47:32] odd_word_low,
	// [63:48] odd_word_high, [65:64] decisions_a, [67:66] decisions_b,
	// [73:68] pair_index, [88:74] metric_spread, [104:89] mean_metric,
	// [111:105] zero
	output logic [111:0]        m_tdata,
	output logic                m_tlast,   // stage_last

	// configuration writes
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [MetricW-1:0]  cfg_data
);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_offset <= '0;
			cfg_q.scale_bypass <= 1'b0;
			cfg_q.select_min   <= 1'b0;
			cfg_q.trellis_log2 <= TrellisLog2Rst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgScaleOffset: cfg_q.scale_offset <= cfg_data;
				CfgScaleBypass: cfg_q.scale_bypass <= cfg_data[0];
				CfgSelectMin:   cfg_q.select_min   <= cfg_data[0];
				CfgTrellisLog2: cfg_q.trellis_log2 <= cfg_data[LogW-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the result register drains when the consumer takes it or is
	// empty; stage 1 advances into it at the same edge, so a full pipeline still
	// takes a new transfer every cycle while m_tready stays high.
	logic          v_s1, v_s2;
	logic          adv2, step;
	logic [127:0]  data_s1;

	assign adv2     = !v_s2 || m_tready;
	assign step     = v_s1 && adv2;
	assign s_tready = !v_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	// hold the input item until stage 2 takes it
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata;
	end

	// butterflies; bypass forces the offset to zero
	metric_t offset_eff;
	bfly_t   bf_a, bf_b;

	assign offset_eff = cfg_q.scale_bypass ? '0 : cfg_q.scale_offset;

	vacs_bfly u_bfly_a (
		.p1      (data_s1[15:0]),
		.p2      (data_s1[31:16]),
		.m1      (data_s1[47:32]),
		.m2      (data_s1[63:48]),
		.offset  (offset_eff),
		.use_min (cfg_q.select_min),
		.res     (bf_a)
	);

	vacs_bfly u_bfly_b (
		.p1      (data_s1[79:64]),
		.p2      (data_s1[95:80]),
		.m1      (data_s1[111:96]),
		.m2      (data_s1[127:112]),
		.offset  (offset_eff),
		.use_min (cfg_q.select_min),
		.res     (bf_b)
	);

	// stage bookkeeping advances once per item moving into the result register
	acc_out_t acc;

	vacs_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.bf_a   (bf_a),
		.bf_b   (bf_b),
		.res    (acc)
	);

	// result register
	logic [111:0] data_s2;
	logic         last_s2;

	always_ff @(posedge clk) begin
		if (step) begin
			data_s2 <= {7'd0, acc.mean, acc.spread, acc.pair_index,
				bf_b.dec, bf_a.dec,
				bf_b.surv_second, bf_a.surv_second,
				bf_b.surv_first, bf_a.surv_first};
			last_s2 <= acc.stage_last;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;

`ifndef SYNTHESIS
	// spread and mean are reported only on the last item of a stage
	a_stats_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[88:74] == '0 && m_tdata[104:89] == '0))
		else $error("spread or mean nonzero on a non-last result");

	// an empty result register must never stall the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// consecutive results within a stage carry consecutive pair indexes
	a_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) ##1 m_tvalid
		|-> (m_tdata[73:68] == $past(m_tdata[73:68]) + 6'd1))
		else $error("pair index did not advance within a stage");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Viterbi ACS stage core (viterbi_acs_stage_core).
// Directed table first, then randomized stages under changing register settings.
// Depends on vacs_pkg and the RTL of the block; no files or arguments are read.
`timescale 1ns / 1ps

module tb_top;
	import vacs_pkg::*;

	localparam int RandItems  = 1950;
	localparam int CycleLimit = 500000;
	localparam int DrainWait  = 4;     // two-stage pipeline, plus margin
	localparam int HoldPeriod = 4000;  // receiver holds off once per period
	localparam int HoldStart  = 1000;
	localparam int HoldLen    = 300;

	// result word exactly as it sits on m_tdata, lowest field last
	typedef struct packed {
		logic [6:0]         pad;
		metric_t            mean;
		logic [SpreadW-1:0] spread;
		logic [CntW-1:0]    pair;
		logic [1:0]         dec_b;
		logic [1:0]         dec_a;
		metric_t            odd_hi;
		metric_t            odd_lo;
		metric_t            even_hi;
		metric_t            even_lo;
	} acs_word_t;

	typedef struct packed {
		acs_word_t w;
		logic      last;
	} acs_exp_t;

	// a typed-in expectation that overrides the predictor for one item
	typedef struct packed {
		logic     on;
		acs_exp_t exp;
	} pin_t;

	// one row of the directed table: a register write or an item
	typedef struct packed {
		logic               is_cfg;
		logic [CfgIdxW-1:0] idx;
		logic [MetricW-1:0] val;
		logic [127:0]       data;
		pin_t               pin;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [127:0]        s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [111:0]        m_tdata;
	logic                m_tlast;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [MetricW-1:0]  cfg_data;

	viterbi_acs_stage_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: own copy of the registers and of the stage accumulators
	// ------------------------------------------------------------------
	int         ofs_reg;
	logic       bypass_reg;
	logic       min_mode;
	logic [3:0] log2_reg;

	int pair_cnt;
	int ext_even;
	int ext_odd;
	int stage_sum;

	acs_exp_t pending_words[$];   // expected results, oldest first
	pin_t     pinned_q[$];        // one entry per offered item, in order
	int       n_sent;
	int       n_seen;
	int       errors;
	int       burst_left;

	function automatic int clamp16(input int v);
		if (v < -32768)
			return -32768;
		if (v > 32767)
			return 32767;
		return v;
	endfunction

	function automatic int keep(input logic use_min, input int x, input int y);
		if (use_min)
			return (x < y) ? x : y;
		return (x > y) ? x : y;
	endfunction

	function automatic int lane(input logic [127:0] d, input int i);
		return int'($signed(d[16*i +: 16]));
	endfunction

	function automatic int eff_log2(input logic [3:0] k);
		if (k < 4'd2)
			return 2;
		if (k > 4'(MaxStateLog2))
			return MaxStateLog2;
		return int'(k);
	endfunction

	// one butterfly: add, compare, select, and fold candidates into the extremes
	function automatic void butterfly_acs(input int p1, input int p2, input int m1, input int m2,
			output int s1, output int s2, output logic [1:0] dec);
		int off;
		int a;
		int b;
		int t1;
		int t2;
		int t3;
		int t4;
		off = bypass_reg ? 0 : ofs_reg;
		a = clamp16(p1 - off);
		b = clamp16(p2 - off);
		t1 = clamp16(a + m1);
		t2 = clamp16(b + m2);
		t3 = clamp16(a - m1);
		t4 = clamp16(b - m2);
		dec = 2'b00;
		// ties go to the first state in max mode, to the second in min mode
		if (!min_mode) begin
			if (t1 >= t2) s1 = t1; else begin s1 = t2; dec[0] = 1'b1; end
			if (t3 >= t4) s2 = t3; else begin s2 = t4; dec[1] = 1'b1; end
		end else begin
			if (t1 >= t2) begin s1 = t2; dec[0] = 1'b1; end else s1 = t1;
			if (t3 >= t4) begin s2 = t4; dec[1] = 1'b1; end else s2 = t3;
		end
		ext_even = keep(min_mode, keep(min_mode, ext_even, t1), t3);
		ext_odd  = keep(min_mode, keep(min_mode, ext_odd, t2), t4);
	endfunction

	// work out the result word of one butterfly pair and advance the stage
	function automatic acs_exp_t predict_pair(input logic [127:0] d);
		acs_exp_t   e;
		int         k;
		int         last_idx;
		int         a1;
		int         a2;
		int         b1;
		int         b2;
		int         diff;
		int         spread;
		int         mean;
		logic [1:0] da;
		logic [1:0] db;
		k = eff_log2(log2_reg);
		last_idx = (1 << (k - 2)) - 1;
		// a new stage restarts the extremes under the current mode
		if (pair_cnt == 0) begin
			ext_even = min_mode ? 32767 : -32767;
			ext_odd = ext_even;
			stage_sum = 0;
		end
		butterfly_acs(lane(d, 0), lane(d, 1), lane(d, 2), lane(d, 3), a1, a2, da);
		butterfly_acs(lane(d, 4), lane(d, 5), lane(d, 6), lane(d, 7), b1, b2, db);
		stage_sum += a1 + a2 + b1 + b2;
		e = '0;
		e.w.even_lo = 16'(a1);
		e.w.even_hi = 16'(b1);
		e.w.odd_lo  = 16'(a2);
		e.w.odd_hi  = 16'(b2);
		e.w.dec_a   = da;
		e.w.dec_b   = db;
		e.w.pair    = 6'(pair_cnt);
		// an index at or past the end of the current size closes the stage
		e.last = (pair_cnt >= last_idx);
		if (e.last) begin
			diff = ext_odd - ext_even;
			if (diff > 32767 || diff < -32767)
				spread = 32767;
			else
				spread = (diff >= 0) ? diff : -diff;
			mean = stage_sum >>> k;
			e.w.spread = 15'(spread);
			e.w.mean = 16'(mean);
			pair_cnt = 0;
		end else begin
			pair_cnt = (pair_cnt + 1) & 63;
		end
		return e;
	endfunction

	// ------------------------------------------------------------------
	// Result check: every transfer on the master side against the oldest
	// pending word, field by field
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		acs_exp_t  e;
		acs_word_t got;
		pin_t      pin;
		if (arst_n) begin
			// predict on every input transfer; a pinned row replaces the prediction
			if (s_tvalid && s_tready) begin
				e = predict_pair(s_tdata);
				pin = '0;
				if (pinned_q.size() != 0)
					pin = pinned_q.pop_front();
				if (pin.on)
					e = pin.exp;
				pending_words.push_back(e);
			end
			if (m_tvalid && m_tready) begin
				got = acs_word_t'(m_tdata);
				if (pending_words.size() == 0) begin
					errors++;
					$display("%0t ns: result with nothing pending, actual %h last %b",
						$time, m_tdata, m_tlast);
				end else begin
					e = pending_words.pop_front();
					check_field("even_word_low", int'(e.w.even_lo), int'(got.even_lo));
					check_field("even_word_high", int'(e.w.even_hi), int'(got.even_hi));
					check_field("odd_word_low", int'(e.w.odd_lo), int'(got.odd_lo));
					check_field("odd_word_high", int'(e.w.odd_hi), int'(got.odd_hi));
					check_field("decisions_a", int'(e.w.dec_a), int'(got.dec_a));
					check_field("decisions_b", int'(e.w.dec_b), int'(got.dec_b));
					check_field("pair_index", int'(e.w.pair), int'(got.pair));
					check_field("stage_last", int'(e.last), int'(m_tlast));
					check_field("metric_spread", int'(e.w.spread), int'(got.spread));
					check_field("mean_metric", int'(e.w.mean), int'(got.mean));
					check_field("pad", int'(e.w.pad), int'(got.pad));
				end
				n_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver pacing: modes of its own, and a long hold-off once per
	// period so the pipeline fills and back-pressures the input
	// ------------------------------------------------------------------
	int rx_cyc;
	int rx_mode;
	int rx_left;

	always @(posedge clk) begin
		rx_cyc++;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		if ((rx_cyc % HoldPeriod) >= HoldStart && (rx_cyc % HoldPeriod) < HoldStart + HoldLen)
			m_tready <= 1'b0;
		else begin
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ((rx_cyc % 5) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic logic [127:0] pack8(input logic [15:0] pal, input logic [15:0] pah,
			input logic [15:0] bal, input logic [15:0] bah, input logic [15:0] pbl,
			input logic [15:0] pbh, input logic [15:0] bbl, input logic [15:0] bbh);
		return {bbh, bbl, pbh, pbl, bah, bal, pah, pal};
	endfunction

	// offer one item in bursts; hold data until the transfer completes
	task automatic push_item(input logic [127:0] d, input pin_t pin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		pinned_q.push_back(pin);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
		burst_left--;
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MetricW-1:0] v);
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (n_seen != n_sent);
		repeat (DrainWait) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgScaleOffset: ofs_reg = int'($signed(v));
			CfgScaleBypass: bypass_reg = v[0];
			CfgSelectMin:   min_mode = v[0];
			CfgTrellisLog2: log2_reg = v[3:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] rand_metric(input int style);
		case (style)
			0: return 16'($urandom());
			1: return 16'($signed(12'($urandom())));
			default: begin
				case ($urandom_range(0, 5))
					0:       return 16'h7FFF;
					1:       return 16'h8000;
					2:       return 16'h7FFE;
					3:       return 16'h8001;
					4:       return 16'h0000;
					default: return 16'($urandom());
				endcase
			end
		endcase
	endfunction

	function automatic logic [127:0] rand_pair();
		logic [127:0] d;
		int           style;
		style = $urandom_range(0, 2);
		for (int i = 0; i < 8; i++)
			d[16*i +: 16] = rand_metric(style);
		return d;
	endfunction

	function automatic step_t item_row(input logic [127:0] d);
		step_t r;
		r = '0;
		r.data = d;
		return r;
	endfunction

	function automatic step_t cfg_row(input logic [CfgIdxW-1:0] idx, input logic [15:0] v);
		step_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = v;
		return r;
	endfunction

	step_t plan[$];

	// directed table: reset state, saturation extremes, ties in both modes,
	// offset and bypass extremes, out-of-range sizes, size change mid-stage
	task automatic build_plan();
		step_t r;
		// all zero at reset: ties keep the first state, nothing else moves
		r = item_row('0);
		r.pin.on = 1'b1;
		plan.push_back(r);
		// sum clamps at the top
		r = item_row(pack8(16'h7FFF, 0, 16'h7FFF, 0, 0, 0, 0, 0));
		r.pin.on = 1'b1;
		r.pin.exp.w.even_lo = MetricMax;
		r.pin.exp.w.pair = 6'd1;
		plan.push_back(r);
		// difference clamps at the bottom; both choices go to the second state
		r = item_row(pack8(16'h8000, 0, 16'h7FFF, 0, 0, 0, 0, 0));
		r.pin.on = 1'b1;
		r.pin.exp.w.dec_a = 2'b11;
		r.pin.exp.w.pair = 6'd2;
		plan.push_back(r);
		plan.push_back(item_row({8{16'h7FFF}}));
		plan.push_back(item_row({8{16'h8000}}));
		// shrink mid-stage: the next item closes the stage
		plan.push_back(cfg_row(CfgTrellisLog2, 16'd2));
		plan.push_back(item_row(pack8(16'h1234, 16'h0F0F, 16'h0100, 16'hFF00,
			16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF)));
		// one-item stage whose extremes are too far apart: spread saturates
		r = item_row(pack8(16'h7FFF, 16'h8000, 0, 0, 16'h7FFF, 16'h8000, 0, 0));
		r.pin.on = 1'b1;
		r.pin.exp.w.even_lo = MetricMax;
		r.pin.exp.w.even_hi = MetricMax;
		r.pin.exp.w.odd_lo = MetricMax;
		r.pin.exp.w.odd_hi = MetricMax;
		r.pin.exp.w.spread = SpreadMax;
		r.pin.exp.w.mean = MetricMax;
		r.pin.exp.last = 1'b1;
		plan.push_back(r);
		// min mode: equal candidates go to the second state
		plan.push_back(cfg_row(CfgSelectMin, 16'd1));
		plan.push_back(item_row(pack8(16'd100, 16'd100, 0, 0, 16'd100, 16'd100, 0, 0)));
		plan.push_back(item_row(pack8(16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF)));
		// most negative offset pushes the path metrics to the top, all but 16'h8000, which lands on zero
		plan.push_back(cfg_row(CfgScaleOffset, 16'h8000));
		plan.push_back(item_row(pack8(16'h7FFF, 0, 16'h7FFF, 16'h8000,
			16'h8000, 16'h0001, 16'h0010, 16'hFFF0)));
		plan.push_back(cfg_row(CfgScaleBypass, 16'd1));
		plan.push_back(item_row(pack8(16'h7FFF, 0, 16'h7FFF, 16'h8000,
			16'h8000, 16'h0001, 16'h0010, 16'hFFF0)));
		plan.push_back(cfg_row(CfgScaleBypass, 16'd0));
		plan.push_back(cfg_row(CfgScaleOffset, 16'h7FFF));
		plan.push_back(item_row(pack8(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h0000, 16'hFFFF, 16'h4000, 16'hC000)));
		// sizes outside the range act as the nearest end
		plan.push_back(cfg_row(CfgSelectMin, 16'd0));
		plan.push_back(cfg_row(CfgTrellisLog2, 16'd0));
		plan.push_back(item_row(pack8(16'd5, 16'd7, 16'd3, 16'd1, 16'hFFFB, 16'd2, 16'd9, 16'd4)));
		plan.push_back(cfg_row(CfgTrellisLog2, 16'd15));
		plan.push_back(item_row(pack8(16'd10, 16'd20, 16'd30, 16'd40,
			16'd50, 16'd60, 16'd70, 16'd80)));
		plan.push_back(item_row(pack8(16'hFFF6, 16'hFFEC, 16'd30, 16'd40,
			16'd50, 16'hFFC4, 16'd70, 16'd80)));
		// past the end of the new size: closes at once
		plan.push_back(cfg_row(CfgTrellisLog2, 16'd3));
		plan.push_back(item_row(pack8(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8)));
		plan.push_back(item_row(pack8(16'd8, 16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1)));
	endtask

	function automatic logic [15:0] rand_offset();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'h8000;
			2:       return 16'h7FFF;
			3:       return 16'($signed(10'($urandom())));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [3:0] rand_log2();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 4'($urandom_range(2, 5));
			6, 7:             return 4'($urandom_range(6, 8));
			8:                return 4'd8;
			default:          return 4'($urandom_range(0, 15));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin : watchdog
		for (int c = 0; c < CycleLimit; c++)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int   rand_items;
		int   len;
		int   n;
		pin_t no_pin;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b1;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		ofs_reg = 0;
		bypass_reg = 1'b0;
		min_mode = 1'b0;
		log2_reg = TrellisLog2Rst;
		pair_cnt = 0;
		ext_even = -32767;
		ext_odd = -32767;
		stage_sum = 0;
		n_sent = 0;
		n_seen = 0;
		errors = 0;
		burst_left = 0;
		rx_cyc = 0;
		rx_mode = 0;
		rx_left = 0;
		rand_items = 0;
		no_pin = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		build_plan();
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				push_item(plan[i].data, plan[i].pin);
		end

		// random phases: a fresh subset of registers, then mostly whole stages,
		// sometimes a partial one so the next size change lands mid-stage
		while (rand_items < RandItems) begin
			if ($urandom_range(0, 1))
				write_reg(CfgScaleOffset, rand_offset());
			if ($urandom_range(0, 2) == 0)
				write_reg(CfgScaleBypass, 16'($urandom()));
			if ($urandom_range(0, 1))
				write_reg(CfgSelectMin, 16'($urandom()));
			if ($urandom_range(0, 1))
				write_reg(CfgTrellisLog2, {12'($urandom()), rand_log2()});
			len = 1 << (eff_log2(log2_reg) - 2);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, len);
			else
				n = len * ((len >= 32) ? 1 : $urandom_range(1, 3));
			repeat (n) begin
				push_item(rand_pair(), no_pin);
				rand_items++;
			end
		end

		// drain, then allow for the pipeline depth
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (n_seen != n_sent);
		repeat (DrainWait * 4) @(posedge clk);

		if (pending_words.size() != 0) begin
			errors++;
			$display("%0t ns: %0d expected results never arrived", $time, pending_words.size());
		end
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
